### hw/rtl/tpcg_pkg.sv
// Shared types and constants for the text/PCG cell row compositor.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package tpcg_pkg;

  // Item kinds carried on the input tuser.
  typedef enum logic [2:0] {
    OP_RENDER   = 3'd0,
    OP_WR_CHAR  = 3'd1,
    OP_WR_BLUE  = 3'd2,
    OP_WR_RED   = 3'd3,
    OP_WR_GREEN = 3'd4
  } opcode_t;

  // Configuration register indexes.
  localparam logic CFG_PCG_ON_TOP = 1'b0;
  localparam logic CFG_PCG_ENABLE = 1'b1;

  // Field widths and memory geometry.
  localparam int OPCODE_W    = 3;
  localparam int WADDR_W     = 13;
  localparam int BYTE_W      = 8;
  localparam int ROW_W       = 3;
  localparam int COLOUR_W    = 3;
  localparam int PIXELS      = 8;
  localparam int IN_DATA_W   = 56;
  localparam int OUT_DATA_W  = PIXELS * COLOUR_W;
  localparam int CHAR_ADDR_W = 12;
  localparam int PCG_ADDR_W  = 13;
  localparam int CHAR_DEPTH  = 4096;
  localparam int PCG_DEPTH   = 8192;

  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Bit positions of the fields in the input tdata.
  localparam int F_WADDR = 0;
  localparam int F_WDATA = 13;
  localparam int F_TCODE = 21;
  localparam int F_TATTR = 29;
  localparam int F_PCODE = 37;
  localparam int F_PATTR = 45;
  localparam int F_ROW   = 53;

  // One fetched cell row, waiting to be composed.
  typedef struct packed {
    logic [BYTE_W-1:0]   glyph;
    logic [BYTE_W-1:0]   blue;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   green;
    logic [COLOUR_W-1:0] fg;
    logic [COLOUR_W-1:0] bg;
    logic                text_on;
    logic                pcg_cell;
  } cell_row_t;

  // Push and pop strobes driven into the queue.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

endpackage

### hw/rtl/text_pcg_cell_row_compositor_core.sv
// Top level of the text/PCG cell row compositor.
// Depends on tpcg_pkg, tpcg_front, tpcg_queue and tpcg_back.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+---------------------------------------
//  s_*      | in        | s_tvalid/s_tready  | s_tuser opcode, s_tdata cell or write
//  m_*      | out       | m_tvalid/m_tready  | m_tdata eight colour indices
//  cfg_*    | in        | cfg_valid/cfg_ready| cfg_index register, cfg_data value
//
// One beat per clock in both directions when the sink keeps up; an accepted render beat
// passes through the pattern read register, a queue entry and the output register, in
// that order, before it is on m_tdata. The single port of each pattern memory sets the
// rate: one write or one read per cycle.
// Reset is synchronous; it clears the pipeline valids, the queue and both config bits,
// while memory contents stay undefined until written. A stalled sink fills the queue,
// after which s_tready drops; write beats take the same path through the front.

module text_pcg_cell_row_compositor_core #(
  parameter int QUEUE_DEPTH = tpcg_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: write_address, write_data, text_code, text_attr, pcg_code, pcg_attr, row
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [tpcg_pkg::IN_DATA_W-1:0]    s_tdata,
  // s_tuser: opcode
  input  logic [tpcg_pkg::OPCODE_W-1:0]     s_tuser,
  // m_tdata: pixel_colours
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [tpcg_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic                              cfg_data
);

  logic                             pcg_on_top;
  logic                             pcg_enable;
  logic                             q_push;
  logic                             q_pop;
  logic                             q_not_empty;
  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;
  tpcg_pkg::cell_row_t              q_entry;
  tpcg_pkg::cell_row_t              q_head;
  tpcg_pkg::queue_ctl_t             q_ctl;

  // Configuration registers; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pcg_on_top <= 1'b0;
      pcg_enable <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tpcg_pkg::CFG_PCG_ON_TOP: pcg_on_top <= cfg_data;
        tpcg_pkg::CFG_PCG_ENABLE: pcg_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  tpcg_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_count  (q_count),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  assign q_ctl.push = q_push;
  assign q_ctl.pop  = q_pop;

  tpcg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .ctl        (q_ctl),
    .push_entry (q_entry),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .count      (q_count)
  );

  tpcg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pcg_on_top (pcg_on_top),
    .pcg_enable (pcg_enable),
    .head       (q_head),
    .not_empty  (q_not_empty),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // An accepted render beat lands in the queue on the next cycle.
  a_render_push: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == tpcg_pkg::OP_RENDER) |=> q_push)
    else $error("render beat did not reach the queue");

  // Write beats and idle cycles never push a row.
  a_no_spurious_push: assert property (@(posedge clk) disable iff (rst)
    !(s_tvalid && s_tready && (s_tuser == tpcg_pkg::OP_RENDER)) |=> !q_push)
    else $error("queue push without a render beat");

  // The queue never holds more rows than it has room for.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
    else $error("queue overflow");

  // A pop happens only from a non-empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("pop from an empty queue");

endmodule

### hw/rtl/tpcg_front.sv
// Front end: accepts input beats, classifies them, writes or reads the pattern memories.
// Depends on tpcg_pkg. Holds the character ROM and the three PCG bit planes.

module tpcg_front #(
  parameter int DEPTH = tpcg_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tpcg_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [tpcg_pkg::OPCODE_W-1:0]       s_tuser,
  input  logic [$clog2(DEPTH+1)-1:0]          q_count,
  output logic                                q_push,
  output tpcg_pkg::cell_row_t                 q_entry
);

  localparam int CW = $clog2(DEPTH+1);

  logic [tpcg_pkg::BYTE_W-1:0] char_rom  [tpcg_pkg::CHAR_DEPTH];
  logic [tpcg_pkg::BYTE_W-1:0] pcg_blue  [tpcg_pkg::PCG_DEPTH];
  logic [tpcg_pkg::BYTE_W-1:0] pcg_red   [tpcg_pkg::PCG_DEPTH];
  logic [tpcg_pkg::BYTE_W-1:0] pcg_green [tpcg_pkg::PCG_DEPTH];

  logic                                accept;
  logic [CW:0]                         used;
  logic [tpcg_pkg::WADDR_W-1:0]        waddr;
  logic [tpcg_pkg::BYTE_W-1:0]         wdata;
  logic [tpcg_pkg::BYTE_W-1:0]         tcode;
  logic [tpcg_pkg::BYTE_W-1:0]         tattr;
  logic [tpcg_pkg::BYTE_W-1:0]         pcode;
  logic [tpcg_pkg::BYTE_W-1:0]         pattr;
  logic [tpcg_pkg::ROW_W-1:0]          row;
  logic [tpcg_pkg::CHAR_ADDR_W-1:0]    char_raddr;
  logic [tpcg_pkg::PCG_ADDR_W-1:0]     pcg_raddr;
  logic                                rd_en;
  logic                                wr_char;
  logic                                wr_blue;
  logic                                wr_red;
  logic                                wr_green;

  // Stage registers that travel alongside the memory read.
  logic                                stage_v;
  logic [tpcg_pkg::COLOUR_W-1:0]       stage_fg;
  logic [tpcg_pkg::COLOUR_W-1:0]       stage_bg;
  logic                                stage_text_on;
  logic                                stage_pcg_cell;
  logic [tpcg_pkg::BYTE_W-1:0]         glyph_q;
  logic [tpcg_pkg::BYTE_W-1:0]         blue_q;
  logic [tpcg_pkg::BYTE_W-1:0]         red_q;
  logic [tpcg_pkg::BYTE_W-1:0]         green_q;

  // Field extraction from the input beat.
  assign waddr = s_tdata[tpcg_pkg::F_WADDR +: tpcg_pkg::WADDR_W];
  assign wdata = s_tdata[tpcg_pkg::F_WDATA +: tpcg_pkg::BYTE_W];
  assign tcode = s_tdata[tpcg_pkg::F_TCODE +: tpcg_pkg::BYTE_W];
  assign tattr = s_tdata[tpcg_pkg::F_TATTR +: tpcg_pkg::BYTE_W];
  assign pcode = s_tdata[tpcg_pkg::F_PCODE +: tpcg_pkg::BYTE_W];
  assign pattr = s_tdata[tpcg_pkg::F_PATTR +: tpcg_pkg::BYTE_W];
  assign row   = s_tdata[tpcg_pkg::F_ROW   +: tpcg_pkg::ROW_W];

  // The text code takes attribute bit 7 as its ninth bit; the PCG code takes bits 7:6.
  assign char_raddr = {tattr[7], tcode, row};
  assign pcg_raddr  = {pattr[7:6], pcode, row};

  // Accept while the queue can still hold every row in flight.
  assign used     = {1'b0, q_count} + (CW+1)'(stage_v);
  assign s_tready = used < (CW+1)'(DEPTH);
  assign accept   = s_tvalid && s_tready;

  // Classify the beat by its kind; unused kinds are dropped.
  always_comb begin
    rd_en    = 1'b0;
    wr_char  = 1'b0;
    wr_blue  = 1'b0;
    wr_red   = 1'b0;
    wr_green = 1'b0;
    unique case (s_tuser)
      tpcg_pkg::OP_RENDER:   rd_en    = accept;
      tpcg_pkg::OP_WR_CHAR:  wr_char  = accept;
      tpcg_pkg::OP_WR_BLUE:  wr_blue  = accept;
      tpcg_pkg::OP_WR_RED:   wr_red   = accept;
      tpcg_pkg::OP_WR_GREEN: wr_green = accept;
      default: ;
    endcase
  end

  // Character ROM: one write or one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_char) begin
      char_rom[waddr[tpcg_pkg::CHAR_ADDR_W-1:0]] <= wdata;
    end
    if (rd_en) begin
      glyph_q <= char_rom[char_raddr];
    end
  end

  // PCG bit planes share one address per cycle.
  always_ff @(posedge clk) begin
    if (wr_blue) begin
      pcg_blue[waddr] <= wdata;
    end
    if (rd_en) begin
      blue_q <= pcg_blue[pcg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_red) begin
      pcg_red[waddr] <= wdata;
    end
    if (rd_en) begin
      red_q <= pcg_red[pcg_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_green) begin
      pcg_green[waddr] <= wdata;
    end
    if (rd_en) begin
      green_q <= pcg_green[pcg_raddr];
    end
  end

  // Cell attributes delayed to line up with the read data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= 1'b0;
    end else begin
      stage_v <= rd_en;
    end
    if (rd_en) begin
      stage_fg       <= tattr[6:4];
      stage_bg       <= tattr[2:0];
      stage_text_on  <= (tcode != '0) || tattr[7];
      stage_pcg_cell <= pattr[3];
    end
  end

  assign q_push = stage_v;

  always_comb begin
    q_entry          = '0;
    q_entry.glyph    = glyph_q;
    q_entry.blue     = blue_q;
    q_entry.red      = red_q;
    q_entry.green    = green_q;
    q_entry.fg       = stage_fg;
    q_entry.bg       = stage_bg;
    q_entry.text_on  = stage_text_on;
    q_entry.pcg_cell = stage_pcg_cell;
  end

endmodule

### hw/rtl/tpcg_queue.sv
// Short queue of fetched cell rows between front and back.
// Depends on tpcg_pkg for the entry type.

module tpcg_queue #(
  parameter int DEPTH = tpcg_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  tpcg_pkg::queue_ctl_t         ctl,
  input  tpcg_pkg::cell_row_t          push_entry,
  output tpcg_pkg::cell_row_t          head,
  output logic                         not_empty,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  tpcg_pkg::cell_row_t entries [DEPTH];
  logic [PW-1:0]       wr_ptr;
  logic [PW-1:0]       rd_ptr;
  logic [PW-1:0]       wr_ptr_next;
  logic [PW-1:0]       rd_ptr_next;
  logic [CW-1:0]       count_next;

  // Pointers wrap at the depth, which need not be a power of two.
  assign wr_ptr_next = (wr_ptr == PW'(DEPTH-1)) ? '0 : wr_ptr + PW'(1);
  assign rd_ptr_next = (rd_ptr == PW'(DEPTH-1)) ? '0 : rd_ptr + PW'(1);

  always_comb begin
    count_next = count;
    unique case ({ctl.push, ctl.pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr <= wr_ptr_next;
      end
      if (ctl.pop) begin
        rd_ptr <= rd_ptr_next;
      end
      count <= count_next;
    end
  end

  // Entry storage; payload needs no reset.
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign head      = entries[rd_ptr];
  assign not_empty = count != '0;

endmodule

### hw/rtl/tpcg_back.sv
// Back end: composes background, text and PCG layers into eight colour indices.
// Depends on tpcg_pkg. Owns the output register of the result channel.

module tpcg_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pcg_on_top,
  input  logic                                pcg_enable,
  input  tpcg_pkg::cell_row_t                 head,
  input  logic                                not_empty,
  output logic                                pop,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tpcg_pkg::OUT_DATA_W-1:0]     m_tdata
);

  logic [tpcg_pkg::OUT_DATA_W-1:0] row_colours;
  logic                            pcg_on;

  assign pcg_on = pcg_enable && head.pcg_cell;

  // Per pixel layering; bit 7 of each byte is the leftmost pixel in the top bits.
  always_comb begin
    logic [tpcg_pkg::COLOUR_W-1:0] colour;
    logic [tpcg_pkg::COLOUR_W-1:0] pidx;
    logic                          tpix;
    logic                          ppix;
    row_colours = '0;
    for (int b = 0; b < tpcg_pkg::PIXELS; b++) begin
      pidx   = {head.green[b], head.red[b], head.blue[b]};
      tpix   = head.text_on && head.glyph[b];
      ppix   = pcg_on && (pidx != '0);
      colour = head.bg;
      if (pcg_on_top) begin
        if (ppix) begin
          colour = pidx;
        end else if (tpix) begin
          colour = head.fg;
        end
      end else begin
        if (tpix) begin
          colour = head.fg;
        end else if (ppix) begin
          colour = pidx;
        end
      end
      row_colours[b*tpcg_pkg::COLOUR_W +: tpcg_pkg::COLOUR_W] = colour;
    end
  end

  // Take the next row whenever the output register is empty or being drained.
  assign pop = not_empty && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (pop) begin
      m_tdata <= row_colours;
    end
  end

endmodule

### sim/testbench.sv
// Self-checking testbench for the text/PCG cell row compositor core.
// Depends on tpcg_pkg and text_pcg_cell_row_compositor_core from hw/rtl.
// Predicts every composed row from shadow copies of the pattern memories and config bits.
`timescale 1ns / 100ps

module testbench;

  // Spare item kinds that the block must ignore.
  localparam int OP_SPARE_FIRST = 5;
  localparam int OP_SPARE_LAST  = 7;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLDOFF     = 10;
  localparam int END_WAIT    = 20;
  localparam int PHASE_ITEMS = 100;

  // Input beat layout, last field in the highest bits.
  typedef struct packed {
    logic [tpcg_pkg::ROW_W-1:0]   row;
    logic [tpcg_pkg::BYTE_W-1:0]  pattr;
    logic [tpcg_pkg::BYTE_W-1:0]  pcode;
    logic [tpcg_pkg::BYTE_W-1:0]  tattr;
    logic [tpcg_pkg::BYTE_W-1:0]  tcode;
    logic [tpcg_pkg::BYTE_W-1:0]  wdata;
    logic [tpcg_pkg::WADDR_W-1:0] waddr;
  } cell_beat_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [tpcg_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [tpcg_pkg::OPCODE_W-1:0]   s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [tpcg_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic                            cfg_index = 1'b0;
  logic                            cfg_data = 1'b0;

  // Shadow state of the block.
  logic [tpcg_pkg::BYTE_W-1:0] glyph_shadow [tpcg_pkg::CHAR_DEPTH];
  logic [tpcg_pkg::BYTE_W-1:0] blue_shadow  [tpcg_pkg::PCG_DEPTH];
  logic [tpcg_pkg::BYTE_W-1:0] red_shadow   [tpcg_pkg::PCG_DEPTH];
  logic [tpcg_pkg::BYTE_W-1:0] green_shadow [tpcg_pkg::PCG_DEPTH];
  bit                          glyph_loaded [tpcg_pkg::CHAR_DEPTH];
  bit                          blue_loaded  [tpcg_pkg::PCG_DEPTH];
  bit                          red_loaded   [tpcg_pkg::PCG_DEPTH];
  bit                          green_loaded [tpcg_pkg::PCG_DEPTH];
  logic                        on_top_shadow = 1'b0;
  logic                        enable_shadow = 1'b0;

  logic [tpcg_pkg::OUT_DATA_W-1:0] expected_rows [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  text_pcg_cell_row_compositor_core uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // Expected colour row for one render beat, leftmost pixel first.
  function automatic logic [tpcg_pkg::OUT_DATA_W-1:0] compose_cell_row(input cell_beat_t b);
    logic [tpcg_pkg::OUT_DATA_W-1:0] pixels;
    logic [8:0]                      text_full;
    logic [tpcg_pkg::BYTE_W-1:0]     glyph, blue, red, green;
    logic [tpcg_pkg::PCG_ADDR_W-1:0] paddr;
    logic [tpcg_pkg::COLOUR_W-1:0]   colour, idx;
    logic                            text_on, pcg_shown, tpix, ppix;
    int                              bit_pos;
    pixels    = '0;
    text_full = {b.tattr[7], b.tcode};
    text_on   = (text_full != 9'd0);
    glyph     = glyph_shadow[{text_full, b.row}];
    pcg_shown = enable_shadow && b.pattr[3];
    paddr     = {b.pattr[7:6], b.pcode, b.row};
    blue      = blue_shadow[paddr];
    red       = red_shadow[paddr];
    green     = green_shadow[paddr];
    for (int k = 0; k < tpcg_pkg::PIXELS; k++) begin
      bit_pos = tpcg_pkg::PIXELS - 1 - k;
      colour  = b.tattr[2:0];
      idx     = {green[bit_pos], red[bit_pos], blue[bit_pos]};
      tpix    = text_on && glyph[bit_pos];
      ppix    = pcg_shown && (idx != '0);
      if (on_top_shadow) begin
        if (tpix) colour = b.tattr[6:4];
        if (ppix) colour = idx;
      end else begin
        if (ppix) colour = idx;
        if (tpix) colour = b.tattr[6:4];
      end
      pixels = {pixels[tpcg_pkg::OUT_DATA_W-tpcg_pkg::COLOUR_W-1:0], colour};
    end
    return pixels;
  endfunction

  // Pattern writes land in the shadow memories; the char ROM keeps 12 address bits.
  task automatic apply_write(input logic [tpcg_pkg::OPCODE_W-1:0] op, input cell_beat_t b);
    case (op)
      tpcg_pkg::OP_WR_CHAR: begin
        glyph_shadow[b.waddr[tpcg_pkg::CHAR_ADDR_W-1:0]] = b.wdata;
        glyph_loaded[b.waddr[tpcg_pkg::CHAR_ADDR_W-1:0]] = 1'b1;
      end
      tpcg_pkg::OP_WR_BLUE: begin
        blue_shadow[b.waddr] = b.wdata;
        blue_loaded[b.waddr] = 1'b1;
      end
      tpcg_pkg::OP_WR_RED: begin
        red_shadow[b.waddr] = b.wdata;
        red_loaded[b.waddr] = 1'b1;
      end
      tpcg_pkg::OP_WR_GREEN: begin
        green_shadow[b.waddr] = b.wdata;
        green_loaded[b.waddr] = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic cell_beat_t random_beat();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[tpcg_pkg::IN_DATA_W-1:0];
  endfunction

  // Sends one input beat; called and returning at a falling edge.
  task automatic send_beat(input logic [tpcg_pkg::OPCODE_W-1:0] op, input cell_beat_t b);
    if ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (op == tpcg_pkg::OP_RENDER) expected_rows.push_back(compose_cell_row(b));
    else apply_write(op, b);
    if (op <= tpcg_pkg::OP_WR_GREEN) items_sent++;
    @(negedge clk);
  endtask

  task automatic send_write(input logic [tpcg_pkg::OPCODE_W-1:0] op,
                            input logic [tpcg_pkg::WADDR_W-1:0] addr,
                            input logic [tpcg_pkg::BYTE_W-1:0] data);
    cell_beat_t b;
    b       = random_beat();
    b.waddr = addr;
    b.wdata = data;
    send_beat(op, b);
  endtask

  task automatic send_render(input logic [7:0] tcode, input logic [7:0] tattr,
                             input logic [7:0] pcode, input logic [7:0] pattr,
                             input logic [2:0] row);
    cell_beat_t b;
    b       = random_beat();
    b.tcode = tcode;
    b.tattr = tattr;
    b.pcode = pcode;
    b.pattr = pattr;
    b.row   = row;
    send_beat(tpcg_pkg::OP_RENDER, b);
  endtask

  // Stops the sender until every predicted row has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_rows.size() != 0) @(negedge clk);
  endtask

  // Config writes only happen with the pipeline empty and settled.
  task automatic write_register(input logic index, input logic value);
    drain_results();
    repeat (HOLDOFF) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (index == tpcg_pkg::CFG_PCG_ON_TOP) on_top_shadow = value;
    else enable_shadow = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Loads any pattern byte a render would read that has not been written yet.
  task automatic load_missing(input cell_beat_t b);
    logic [tpcg_pkg::CHAR_ADDR_W-1:0] caddr;
    logic [tpcg_pkg::PCG_ADDR_W-1:0]  paddr;
    caddr = {b.tattr[7], b.tcode, b.row};
    paddr = {b.pattr[7:6], b.pcode, b.row};
    if (!glyph_loaded[caddr])
      send_write(tpcg_pkg::OP_WR_CHAR, {1'($urandom_range(1)), caddr}, 8'($urandom));
    if (!blue_loaded[paddr])  send_write(tpcg_pkg::OP_WR_BLUE, paddr, 8'($urandom));
    if (!red_loaded[paddr])   send_write(tpcg_pkg::OP_WR_RED, paddr, 8'($urandom));
    if (!green_loaded[paddr]) send_write(tpcg_pkg::OP_WR_GREEN, paddr, 8'($urandom));
  endtask

  // Mostly loaded renders, some stray writes and a little ignored noise.
  task automatic random_item();
    int                           pick;
    cell_beat_t                   b;
    logic [tpcg_pkg::WADDR_W-1:0] addr;
    pick = $urandom_range(99);
    b    = random_beat();
    if (pick < 8) begin
      send_beat(3'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST)), b);
    end else if (pick < 33) begin
      addr = b.waddr;
      if ($urandom_range(1)) addr[10:3] = 8'($urandom_range(7));
      send_write(3'($urandom_range(tpcg_pkg::OP_WR_GREEN, tpcg_pkg::OP_WR_CHAR)), addr,
                 b.wdata);
    end else begin
      // Half the renders use a small pool of codes so cells are revisited.
      if ($urandom_range(1)) begin
        b.tcode = 8'($urandom_range(7));
        b.pcode = 8'($urandom_range(7));
      end
      load_missing(b);
      send_beat(tpcg_pkg::OP_RENDER, b);
    end
    if ($urandom_range(59) == 0) drain_results();
  endtask

  // Text layer under reset config: bank bit, code zero, address wrap, field extremes.
  task automatic test_text_layer();
    send_write(tpcg_pkg::OP_WR_CHAR, 13'h1FFF, 8'hA5);
    send_write(tpcg_pkg::OP_WR_CHAR, 13'h0000, 8'hFF);
    send_write(tpcg_pkg::OP_WR_CHAR, 13'h0800, 8'h3C);
    send_write(tpcg_pkg::OP_WR_BLUE, 13'h1FFF, 8'h0F);
    send_write(tpcg_pkg::OP_WR_RED, 13'h1FFF, 8'h33);
    send_write(tpcg_pkg::OP_WR_GREEN, 13'h1FFF, 8'h55);
    send_write(tpcg_pkg::OP_WR_BLUE, 13'h0000, 8'hF0);
    send_write(tpcg_pkg::OP_WR_RED, 13'h0000, 8'hCC);
    send_write(tpcg_pkg::OP_WR_GREEN, 13'h0000, 8'hAA);
    send_render(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd7);
    send_render(8'h00, 8'h00, 8'h00, 8'h00, 3'd0);
    send_render(8'h00, 8'hD2, 8'h00, 8'h00, 3'd0);
  endtask

  // PCG visibility, transparency and layer priority.
  task automatic test_pcg_priority();
    write_register(tpcg_pkg::CFG_PCG_ENABLE, 1'b1);
    send_render(8'hFF, 8'hA1, 8'hFF, 8'hFF, 3'd7);
    send_render(8'h00, 8'h06, 8'h00, 8'h08, 3'd0);
    write_register(tpcg_pkg::CFG_PCG_ON_TOP, 1'b1);
    send_render(8'hFF, 8'hA1, 8'hFF, 8'hFF, 3'd7);
    send_render(8'h00, 8'h06, 8'h00, 8'h08, 3'd0);
    send_render(8'hFF, 8'hA1, 8'hFF, 8'hF7, 3'd7);
  endtask

  // Spare kinds aimed at loaded bytes must leave the memories untouched.
  task automatic test_ignored_opcodes();
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
      cell_beat_t b;
      b       = random_beat();
      b.waddr = 13'h1FFF;
      b.wdata = 8'h00;
      send_beat(3'(op), b);
    end
    send_render(8'hFF, 8'hB4, 8'hFF, 8'hFF, 3'd7);
  endtask

  // Random traffic through all four config settings under one idling mode.
  task automatic test_random_traffic(input int src_pct, input int sink_pct);
    int target;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    for (int c = 0; c < 4; c++) begin
      write_register(tpcg_pkg::CFG_PCG_ON_TOP, c[0]);
      write_register(tpcg_pkg::CFG_PCG_ENABLE, c[1]);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) random_item();
    end
  endtask

  // Receiver readiness changes on the falling edge.
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  task automatic report_row_mismatch(input string what,
                                     input logic [tpcg_pkg::OUT_DATA_W-1:0] want,
                                     input logic [tpcg_pkg::OUT_DATA_W-1:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%s: expected %h, got %h", what, want, got);
  endtask

  // Every output beat is compared with the oldest predicted row.
  always @(posedge clk) begin : check_rows
    logic [tpcg_pkg::OUT_DATA_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_rows.size() == 0) begin
        report_row_mismatch("unexpected row", 'x, m_tdata);
      end else begin
        want = expected_rows.pop_front();
        if (m_tdata !== want) report_row_mismatch("pixel_colours", want, m_tdata);
      end
    end
  end

  // Ends the run when no channel moves a beat for too long.
  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[text_pcg_cell_row_compositor_core] ERROR");
    $finish;
  end

  initial begin : main_sequence
    src_idle_pct   = 8;
    sink_stall_pct = 82;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_text_layer();
    test_pcg_priority();
    test_ignored_opcodes();
    test_random_traffic(8, 82);
    test_random_traffic(82, 8);
    test_random_traffic(0, 0);
    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (mismatch_count == 0 && expected_rows.size() == 0)
      $display("[text_pcg_cell_row_compositor_core] OK");
    else
      $display("[text_pcg_cell_row_compositor_core] ERROR");
    $finish;
  end

endmodule

### sim.f
hw/rtl/tpcg_pkg.sv
hw/rtl/tpcg_front.sv
hw/rtl/tpcg_queue.sv
hw/rtl/tpcg_back.sv
hw/rtl/text_pcg_cell_row_compositor_core.sv
sim/testbench.sv
